[hw/rtl/sssd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sssd_pkg: shared types and constants of the spin stop sector detector
// Commands, phases, event kinds, register indexes and the state record.
// ----------------------------------------------------------------------------
package sssd_pkg;

	// Sector ring size and the sensors actually scanned
	localparam int NUM_SECTORS  = 15;
	localparam int SENSOR_W     = 15;
	localparam int SCAN_COUNT   = (NUM_SECTORS < SENSOR_W) ? NUM_SECTORS : SENSOR_W;
	localparam int SECT_W       = 4;
	localparam int TIME_W       = 32;
	localparam int TURN_W       = 16;
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 16;

	localparam logic [SENSOR_W-1:0] LED_MASK =
		SENSOR_W'((33'd1 << SCAN_COUNT) - 33'd1);

	// Reset values of the configuration registers
	localparam logic [TURN_W-1:0] TURN_TIME_RST    = 16'd1000;
	localparam logic              ACTIVE_LEVEL_RST = 1'b1;
	localparam logic              TEST_MODE_RST    = 1'b0;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_TURN_TIME    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_LEVEL = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TEST_MODE    = 2'd2;

	// Command codes
	localparam logic [1:0] CMD_SAMPLE = 2'd0;
	localparam logic [1:0] CMD_ARM    = 2'd1;
	localparam logic [1:0] CMD_DISARM = 2'd2;
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	// Detection phases
	localparam logic [1:0] PH_READY  = 2'd0;
	localparam logic [1:0] PH_DIR    = 2'd1;
	localparam logic [1:0] PH_STOP   = 2'd2;
	localparam logic [1:0] PH_UNUSED = 2'd3;

	// Event kinds
	localparam logic [1:0] EV_NONE    = 2'd0;
	localparam logic [1:0] EV_STARTED = 2'd1;
	localparam logic [1:0] EV_STOPPED = 2'd2;

	typedef struct packed {
		logic [TURN_W-1:0] turn_time_ms;
		logic              active_level;
		logic              test_mode;
	} cfg_t;

	typedef struct packed {
		logic [1:0]          phase;
		logic                armed;
		logic [SECT_W-1:0]   last_sector;
		logic [TIME_W-1:0]   last_change_ms;
		logic [SENSOR_W-1:0] number_leds;
		logic [SENSOR_W-1:0] arrow_leds;
	} det_state_t;

	typedef struct packed {
		logic [1:0]          cmd;
		logic [SENSOR_W-1:0] sensors;
		logic [TIME_W-1:0]   now_ms;
	} item_t;

	typedef struct packed {
		logic [1:0]          event_kind;
		logic [SECT_W-1:0]   event_sector;
		logic [SENSOR_W-1:0] number_leds;
		logic [SENSOR_W-1:0] arrow_leds;
		logic                armed;
		logic [1:0]          phase;
	} result_t;

endpackage
`default_nettype wire

[hw/rtl/sssd_ifs.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sssd_ifs: handshake channels of the spin stop sector detector
// Command channel into the block and result channel out of it.
// ----------------------------------------------------------------------------
interface sssd_in_if;
	import sssd_pkg::*;
	logic                valid;
	logic                ready;
	logic [1:0]          cmd;
	logic [SENSOR_W-1:0] sensors;
	logic [TIME_W-1:0]   now_ms;

	modport source (output valid, output cmd, output sensors, output now_ms, input ready);
	modport sink   (input valid, input cmd, input sensors, input now_ms, output ready);
endinterface

interface sssd_out_if;
	import sssd_pkg::*;
	logic                valid;
	logic                ready;
	logic [1:0]          event_kind;
	logic [SECT_W-1:0]   event_sector;
	logic [SENSOR_W-1:0] number_leds;
	logic [SENSOR_W-1:0] arrow_leds;
	logic                armed;
	logic [1:0]          phase;

	modport source (output valid, output event_kind, output event_sector,
		output number_leds, output arrow_leds, output armed, output phase, input ready);
	modport sink   (input valid, input event_kind, input event_sector,
		input number_leds, input arrow_leds, input armed, input phase, output ready);
endinterface
`default_nettype wire

[hw/rtl/spin_stop_sector_detector_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spin_stop_sector_detector_core: spin start and stop sector detection
// Input register, single-pass step logic, detection state and result register.
// ----------------------------------------------------------------------------
//  Channel  Dir  Handshake      Payload
//  in_ch    in   valid/ready    cmd, sensors, now_ms
//  out_ch   out  valid/ready    event_kind, event_sector, number_leds,
//                               arrow_leds, armed, phase
//  cfg      in   cfg_we         cfg_index, cfg_data
//
//  One item per cycle sustained while out_ch does not stall; items pass the
//  input register, then the step logic into the result register. The state update
//  is a single pass through the step logic, so the next item can follow directly.
//  Reset clears valid flags and detection state, and loads register defaults.
//  A stalled result holds the input register; in_ch.ready drops only when
//  both the input register and the result register are full and out_ch stalls.
// ----------------------------------------------------------------------------
module spin_stop_sector_detector_core import sssd_pkg::*; (
	input  wire                   clk,
	input  wire                   arst_n,
	sssd_in_if.sink               in_ch,
	sssd_out_if.source            out_ch,
	input  wire                   cfg_we,
	input  wire [CFG_IDX_W-1:0]   cfg_index,
	input  wire [CFG_DATA_W-1:0]  cfg_data
);

	cfg_t       cfg_q;
	det_state_t state_q;
	det_state_t state_nxt;
	item_t      item_s1;
	logic       valid_s1;
	result_t    res_s2;
	result_t    res_nxt;
	logic       valid_s2;
	logic       advance;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.turn_time_ms <= TURN_TIME_RST;
			cfg_q.active_level <= ACTIVE_LEVEL_RST;
			cfg_q.test_mode    <= TEST_MODE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_TURN_TIME:    cfg_q.turn_time_ms <= cfg_data;
				REG_ACTIVE_LEVEL: cfg_q.active_level <= cfg_data[0];
				REG_TEST_MODE:    cfg_q.test_mode    <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Pipeline flow control
	assign advance     = !valid_s2 || out_ch.ready;
	assign in_ch.ready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			item_s1.cmd     <= in_ch.cmd;
			item_s1.sensors <= in_ch.sensors;
			item_s1.now_ms  <= in_ch.now_ms;
		end
	end

	sssd_step u_step (
		.cfg  (cfg_q),
		.cur  (state_q),
		.item (item_s1),
		.nxt  (state_nxt),
		.res  (res_nxt)
	);

	// Detection state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (valid_s1 && advance) begin
			state_q <= state_nxt;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && advance) begin
			res_s2 <= res_nxt;
		end
	end

	assign out_ch.valid        = valid_s2;
	assign out_ch.event_kind   = res_s2.event_kind;
	assign out_ch.event_sector = res_s2.event_sector;
	assign out_ch.number_leds  = res_s2.number_leds;
	assign out_ch.arrow_leds   = res_s2.arrow_leds;
	assign out_ch.armed        = res_s2.armed;
	assign out_ch.phase        = res_s2.phase;

	// A stop event always disarms and returns to ready
	a_stop_disarms: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && res_s2.event_kind == EV_STOPPED) |-> (!res_s2.armed && res_s2.phase == PH_READY))
		else $error("stop event without disarm");

	// A sector number is carried only by a stop event
	a_sector_only_on_stop: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && res_s2.event_kind != EV_STOPPED) |-> (res_s2.event_sector == '0))
		else $error("event sector outside a stop event");

	// A start event moves to waiting for stop
	a_start_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && res_s2.event_kind == EV_STARTED) |-> (res_s2.phase == PH_STOP && res_s2.armed))
		else $error("start event in wrong phase");

	// A held item in the input register does not touch the detection state
	a_state_holds_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !out_ch.ready) |=> $stable(state_q))
		else $error("state changed while result stalled");

	// The detection state never holds the unused phase code
	a_phase_code: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.phase != PH_UNUSED)
		else $error("unused phase code reached");

endmodule
`default_nettype wire

[hw/rtl/sssd_step.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sssd_step: next-state and result logic for one item
// Priority encode of the active sensor, timeout compare and phase update.
// ----------------------------------------------------------------------------
module sssd_step import sssd_pkg::*; (
	input  wire  cfg_t       cfg,
	input  wire  det_state_t cur,
	input  wire  item_t      item,
	output det_state_t       nxt,
	output result_t          res
);

	logic [SECT_W-1:0]   act_sector;
	logic                act_found;
	logic [TIME_W-1:0]   elapsed;
	logic                dir_timeout;
	logic                stop_timeout;
	logic [SENSOR_W-1:0] masked;
	logic [1:0]          kind;
	logic [SECT_W-1:0]   sector;

	// Lowest-numbered sensor at the active level
	always_comb begin
		act_sector = '0;
		act_found  = 1'b0;
		for (int i = SCAN_COUNT - 1; i >= 0; i--) begin
			if (item.sensors[i] == cfg.active_level) begin
				act_sector = SECT_W'(i);
				act_found  = 1'b1;
			end
		end
	end

	// Elapsed time modulo 2^32 against one and two turn times
	assign elapsed      = item.now_ms - cur.last_change_ms;
	assign dir_timeout  = elapsed >= {{(TIME_W-TURN_W-1){1'b0}}, cfg.turn_time_ms, 1'b0};
	assign stop_timeout = elapsed >= {{(TIME_W-TURN_W){1'b0}}, cfg.turn_time_ms};
	assign masked       = item.sensors & LED_MASK;

	// Command handling and detection sequence
	always_comb begin
		nxt    = cur;
		kind   = EV_NONE;
		sector = '0;
		case (item.cmd)
			CMD_SAMPLE: begin
				if (cfg.test_mode) begin
					nxt.number_leds = masked;
					nxt.arrow_leds  = masked;
				end else if (cur.armed) begin
					nxt.number_leds = masked;
					unique case (cur.phase)
						PH_READY: begin
							if (act_found) begin
								nxt.last_change_ms = item.now_ms;
								nxt.last_sector    = act_sector;
								nxt.phase          = PH_DIR;
							end
						end
						PH_DIR: begin
							if (dir_timeout) begin
								nxt.phase       = PH_READY;
								nxt.number_leds = '0;
								nxt.arrow_leds  = '0;
							end else if (act_found) begin
								nxt.last_change_ms = item.now_ms;
								if (act_sector != cur.last_sector) begin
									nxt.last_sector = act_sector;
									nxt.phase       = PH_STOP;
									kind            = EV_STARTED;
								end
							end
						end
						PH_STOP: begin
							if (stop_timeout) begin
								kind   = EV_STOPPED;
								sector = (act_found ? act_sector : cur.last_sector) + SECT_W'(1);
								nxt.armed       = 1'b0;
								nxt.phase       = PH_READY;
								nxt.number_leds = '0;
								nxt.arrow_leds  = '0;
							end else if (act_found && act_sector != cur.last_sector) begin
								nxt.last_change_ms = item.now_ms;
								nxt.last_sector    = act_sector;
							end
						end
						default: begin
							// unused phase code falls back to a detection reset
							nxt.phase       = PH_READY;
							nxt.number_leds = '0;
							nxt.arrow_leds  = '0;
						end
					endcase
				end
			end
			CMD_ARM: begin
				nxt.armed       = 1'b1;
				nxt.phase       = PH_READY;
				nxt.number_leds = '0;
				nxt.arrow_leds  = '0;
			end
			CMD_DISARM: begin
				nxt.armed = 1'b0;
			end
			default: ;
		endcase
	end

	// Result shows the state after the step
	always_comb begin
		res.event_kind   = kind;
		res.event_sector = sector;
		res.number_leds  = nxt.number_leds;
		res.arrow_leds   = nxt.arrow_leds;
		res.armed        = nxt.armed;
		res.phase        = nxt.phase;
	end

endmodule
`default_nettype wire
